// ===== sv/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types, character constants and the escape digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    // Default width of the decoded byte counter.
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths.
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 16;
    localparam int CAP_W   = 16;
    localparam int STAT_W  = 2;

    // Characters with a special meaning.
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_0       = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9       = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA      = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ      = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA      = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ      = 8'h7A;
    localparam logic [5:0]        LETTER_BASE  = 6'd10;

    // Escape phase of the decoder.
    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_HIGH   = 2'd1,
        PH_LOW    = 2'd2
    } t_phase;

    // Sticky error codes.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TRUNC = 2'd1,
        ERR_DIGIT = 2'd2
    } t_err;

    // Final status codes reported on the last byte.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_TRUNC = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIGIT = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Decoder state other than the byte counter.
    typedef struct packed {
        t_phase     phase;
        logic [3:0] high_digit;
        t_err       err;
    } t_state;

    // One result item.
    typedef struct packed {
        logic [CHAR_W-1:0]  out_byte;
        logic               byte_valid;
        logic               done_res;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] out_count;
    } t_result;

    // Escape digit: its value and whether the character is a digit at all.
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_digit;

    function automatic t_digit digit_value(input logic [CHAR_W-1:0] c);
        t_digit d;
        logic [CHAR_W-1:0] diff;
        d.ok  = 1'b0;
        d.val = '0;
        diff  = '0;
        if (c >= CHAR_UA && c <= CHAR_UZ) begin
            diff  = c - CHAR_UA;
            d.ok  = 1'b1;
            d.val = diff[5:0] + LETTER_BASE;
        end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
            diff  = c - CHAR_LA;
            d.ok  = 1'b1;
            d.val = diff[5:0] + LETTER_BASE;
        end else if (c >= CHAR_0 && c <= CHAR_9) begin
            diff  = c - CHAR_0;
            d.ok  = 1'b1;
            d.val = diff[5:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/upd_step.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder step logic
// Combinational next state and result for one registered input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_step #(
    parameter int COUNT_BITS = upd_pkg::COUNT_BITS_DEF
) (
    input  wire upd_pkg::t_state                  i_state,
    input  wire logic [COUNT_BITS-1:0]            i_count,
    input  wire logic [upd_pkg::CHAR_W-1:0]       i_char,
    input  wire logic                             i_last,
    input  wire logic [((COUNT_BITS > upd_pkg::CAP_W) ? COUNT_BITS : upd_pkg::CAP_W)-1:0]
                                                  i_cap,
    output upd_pkg::t_state                       o_state,
    output logic [COUNT_BITS-1:0]                 o_count,
    output logic                                  o_has_result,
    output upd_pkg::t_result                      o_result
);

    localparam int CMP_W = (COUNT_BITS > upd_pkg::CAP_W) ? COUNT_BITS : upd_pkg::CAP_W;

    upd_pkg::t_digit            dig;
    upd_pkg::t_state            st;
    logic                       active;
    logic                       bvalid;
    logic [upd_pkg::CHAR_W-1:0] bval;
    logic [COUNT_BITS-1:0]      cnt;
    logic [CMP_W-1:0]           cnt_ext;
    logic [CMP_W-1:0]           old_ext;

    assign dig     = upd_pkg::digit_value(i_char);
    assign old_ext = CMP_W'(i_count);
    assign active  = (i_state.err == upd_pkg::ERR_NONE) && (old_ext < i_cap);

    // Escape parsing while no error is pending and the buffer has room.
    always_comb begin
        st     = i_state;
        bvalid = 1'b0;
        bval   = '0;
        if (active) begin
            st.phase = upd_pkg::PH_NORMAL;
            unique case (i_state.phase)
                upd_pkg::PH_HIGH: begin
                    if (i_last) begin
                        st.err = upd_pkg::ERR_TRUNC;
                    end else if (dig.ok) begin
                        st.high_digit = dig.val[3:0];
                        st.phase      = upd_pkg::PH_LOW;
                    end else begin
                        st.err = upd_pkg::ERR_DIGIT;
                    end
                end
                upd_pkg::PH_LOW: begin
                    if (dig.ok) begin
                        bval   = {i_state.high_digit, 4'b0000} + {2'b00, dig.val};
                        bvalid = 1'b1;
                    end else begin
                        st.err = upd_pkg::ERR_DIGIT;
                    end
                end
                default: begin
                    if (i_char == upd_pkg::CHAR_PLUS) begin
                        bval   = upd_pkg::CHAR_SPACE;
                        bvalid = 1'b1;
                    end else if (i_char == upd_pkg::CHAR_PERCENT) begin
                        if (i_last) begin
                            st.err = upd_pkg::ERR_TRUNC;
                        end else begin
                            st.phase = upd_pkg::PH_HIGH;
                        end
                    end else begin
                        bval   = i_char;
                        bvalid = 1'b1;
                    end
                end
            endcase
        end
    end

    // Counter update wraps at the counter width.
    assign cnt     = i_count + COUNT_BITS'(bvalid);
    assign cnt_ext = CMP_W'(cnt);

    // Result fields; the final status looks at the updated count.
    always_comb begin
        o_result.out_byte   = bval;
        o_result.byte_valid = bvalid;
        o_result.done_res   = i_last;
        o_result.out_count  = cnt_ext[upd_pkg::COUNT_W-1:0];
        o_result.status     = upd_pkg::ST_OK;
        if (i_last) begin
            if (st.err != upd_pkg::ERR_NONE) begin
                o_result.status = upd_pkg::STAT_W'(st.err);
            end else if (cnt_ext < i_cap) begin
                o_result.status = upd_pkg::ST_OK;
            end else begin
                o_result.status = upd_pkg::ST_FULL;
            end
        end
    end

    assign o_has_result = bvalid || i_last;

    // The last byte returns the decoder to its idle state.
    always_comb begin
        if (i_last) begin
            o_state.phase      = upd_pkg::PH_NORMAL;
            o_state.high_digit = '0;
            o_state.err        = upd_pkg::ERR_NONE;
            o_count            = '0;
        end else begin
            o_state = st;
            o_count = cnt;
        end
    end

endmodule

`default_nettype wire

// ===== sv/upd_out_reg.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire upd_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_free,
    output logic                  o_valid,
    output upd_pkg::t_result      o_result
);

    logic             r_valid;
    logic             n_valid;
    upd_pkg::t_result r_result;

    // The slot can take a new result when empty or emptying this cycle.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== sv/url_percent_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder of percent-encoded text, one character per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_ready    i_in_char, i_in_last
//  out       output     o_out_valid / i_out_ready  o_out_byte, o_byte_valid,
//                                                  o_done_res, o_status, o_out_count
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_out_capacity
//
//  One character is accepted per cycle while the output is not stalled. Its
//  result passes through the input register, then the result register, before
//  o_out_valid rises. The decoder state loop updates on every advance, which sets
//  the rate of one character per clock. Characters that give no result are
//  consumed silently. A stalled output holds the result register and then the
//  input register; the input side keeps accepting while either has room.
//  Synchronous active-low reset clears state and sets capacity to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_unit #(
    parameter int COUNT_BITS = upd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [upd_pkg::CHAR_W-1:0]   i_in_char,
    input  wire logic                         i_in_last,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [upd_pkg::CHAR_W-1:0]        o_out_byte,
    output logic                              o_byte_valid,
    output logic                              o_done_res,
    output logic [upd_pkg::STAT_W-1:0]        o_status,
    output logic [upd_pkg::COUNT_W-1:0]       o_out_count,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [upd_pkg::CAP_W-1:0]    i_cfg_out_capacity
);

    localparam int CMP_W = (COUNT_BITS > upd_pkg::CAP_W) ? COUNT_BITS : upd_pkg::CAP_W;

    logic                       r_in_valid;
    logic [upd_pkg::CHAR_W-1:0] r_in_char;
    logic                       r_in_last;
    upd_pkg::t_state            r_state;
    upd_pkg::t_state            n_state;
    logic [COUNT_BITS-1:0]      r_count;
    logic [COUNT_BITS-1:0]      n_count;
    logic [upd_pkg::CAP_W-1:0]  r_cap;
    logic [CMP_W-1:0]           cap_ext;
    logic [CMP_W-1:0]           cap_lim;
    logic [CMP_W-1:0]           cap_use;
    logic                       out_free;
    logic                       advance;
    logic                       in_take;
    logic                       has_result;
    upd_pkg::t_result           step_result;
    upd_pkg::t_result           out_result;

    // Capacity register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= {upd_pkg::CAP_W{1'b1}};
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_out_capacity;
        end
    end

    // Usable capacity is limited by what the counter can hold.
    assign cap_ext = CMP_W'(r_cap);
    assign cap_lim = CMP_W'({COUNT_BITS{1'b1}});
    assign cap_use = (cap_ext < cap_lim) ? cap_ext : cap_lim;

    // A registered character moves on when the result slot can take it.
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_in_char;
            r_in_last <= i_in_last;
        end
    end

    // Decoder state advances with each registered character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= upd_pkg::PH_NORMAL;
            r_state.high_digit <= '0;
            r_state.err        <= upd_pkg::ERR_NONE;
            r_count            <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    upd_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_state      (r_state),
        .i_count      (r_count),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .i_cap        (cap_use),
        .o_state      (n_state),
        .o_count      (n_count),
        .o_has_result (has_result),
        .o_result     (step_result)
    );

    upd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (step_result),
        .i_ready  (i_out_ready),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_out_byte   = out_result.out_byte;
    assign o_byte_valid = out_result.byte_valid;
    assign o_done_res   = out_result.done_res;
    assign o_status     = out_result.status;
    assign o_out_count  = out_result.out_count;

endmodule

`default_nettype wire
